// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the text terminal RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text terminal cell writer.
// No dependencies; used by tcw_ctrl, tcw_dp and the top level.
package tcw_pkg;

    // Field widths fixed by the word formats
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int POS_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Request kinds
    localparam logic REQ_PRINT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Character code that moves the cursor to the next row
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE = 2'd2;

    // Configuration reset values
    localparam logic [6:0] SCREEN_WIDTH_RST   = 7'd80;
    localparam logic [4:0] SCREEN_HEIGHT_RST  = 5'd25;
    localparam logic [7:0] TEXT_ATTRIBUTE_RST = 8'd7;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  cell_index;
    } req_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
    } rsp_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic exec_read;
        logic exec_print;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic set_cursor;
        logic scroll_start;
        logic copy_step;
        logic rowclr_start;
        logic rowclr_step;
        logic scroll_home;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic item_is_read;
        logic item_is_newline;
        logic div_done;
        logic pos_in_area;
        logic copy_done;
        logic rowclr_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Sequencer for the text terminal: reset sweep, item decode, divide, scroll.
// Depends on tcw_pkg (command and status structs) and assert_macros.svh.
`include "assert_macros.svh"

module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tcw_pkg::dp_sts_t  sts,
    output tcw_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_COPY   = 3'd5;
    localparam logic [2:0] S_ROWCLR = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Only the idle state takes a word
    assign req_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.item_is_read)
                begin
                    cmd.exec_read = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (sts.item_is_newline)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.exec_print = 1'b1;
                    state_next     = S_PLACE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = S_PLACE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_PLACE:
            begin
                if (sts.pos_in_area)
                begin
                    cmd.set_cursor = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.scroll_start = 1'b1;
                    state_next       = S_COPY;
                end
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (sts.copy_done)
                begin
                    cmd.rowclr_start = 1'b1;
                    state_next       = S_ROWCLR;
                end
            end
            S_ROWCLR:
            begin
                cmd.rowclr_step = 1'b1;
                if (sts.rowclr_last)
                begin
                    cmd.scroll_home = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TCW_ASSERT_NXT(a_accept_decides, req_valid && !req_stall, state_reg == S_DECIDE,
        "accepted word not decoded next cycle")
    `TCW_ASSERT_NXT(a_div_entry, state_next == S_DIV,
        $past(state_reg) == S_DECIDE || $past(state_reg) == S_DIV,
        "divide entered from a wrong state")

endmodule

// ===== rtl/tcw_dp.sv =====
// Datapath of the text terminal: config, cursor, divider, scroll counters, cell RAM.
// Depends on tcw_pkg, tcw_ram and assert_macros.svh.
`include "assert_macros.svh"

module tcw_dp #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  tcw_pkg::req_word_t                  req_word,
    output tcw_pkg::rsp_word_t                  rsp_word,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  tcw_pkg::dp_cmd_t                    cmd,
    output tcw_pkg::dp_sts_t                    sts
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int PW    = NW + 8;
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(NW + 1);

    // Configuration
    logic [6:0] width_cfg_reg;
    logic [4:0] height_cfg_reg;
    logic [7:0] attr_reg;

    // Geometry
    logic [CW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [CW+HW-1:0] area_prod;
    logic [NW-1:0]    area_reg;
    logic [NW-1:0]    home;

    // Item and cursor
    tcw_pkg::req_word_t item_reg;
    logic [NW-1:0]      cursor_reg;
    logic [PW-1:0]      pos_reg;
    logic               cursor_in_area;
    logic               item_in_range;

    // Remainder unit
    logic [CW-1:0]  rem_reg;
    logic [NW-1:0]  dvd_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [CW:0]    rem_sh;
    logic [CW-1:0]  rem_next;

    // Sweep and scroll counters
    logic [AW-1:0] clr_idx_reg;
    logic [NW-1:0] copy_idx_reg;
    logic [NW-1:0] copy_src;
    logic          copy_issue;
    logic          pend_reg;
    logic [NW-1:0] pend_addr_reg;
    logic [NW-1:0] rowclr_idx_reg;

    // RAM ports
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [tcw_pkg::CELL_W-1:0] rd_data;

    // Result register
    logic               rsp_valid_reg;
    tcw_pkg::rsp_word_t rsp_word_reg;

    // Clamp the geometry to the store
    always_comb
    begin
        if (width_cfg_reg == 7'd0)
        begin
            eff_w = CW'(1);
        end
        else if (32'(width_cfg_reg) > 32'(MAX_COLUMNS))
        begin
            eff_w = CW'(MAX_COLUMNS);
        end
        else
        begin
            eff_w = CW'(width_cfg_reg);
        end

        if (height_cfg_reg == 5'd0)
        begin
            eff_h = HW'(1);
        end
        else if (32'(height_cfg_reg) > 32'(MAX_ROWS))
        begin
            eff_h = HW'(MAX_ROWS);
        end
        else
        begin
            eff_h = HW'(height_cfg_reg);
        end
    end

    assign area_prod = {{HW{1'b0}}, eff_w} * {{CW{1'b0}}, eff_h};
    assign home      = area_reg - NW'(eff_w);

    assign cursor_in_area = (cursor_reg < area_reg);
    assign item_in_range  = ({21'd0, item_reg.cell_index} < 32'(DEPTH));

    // One restoring remainder step
    assign rem_sh   = {rem_reg, dvd_reg[NW-1]};
    assign rem_next = (rem_sh >= {1'b0, eff_w}) ? CW'(rem_sh - {1'b0, eff_w}) : CW'(rem_sh);

    // Scroll copy: read row below, write it in the next cycle
    assign copy_src   = copy_idx_reg + NW'(eff_w);
    assign copy_issue = cmd.copy_step && !sts.copy_done;

    // Status
    assign sts.clr_last        = (32'(clr_idx_reg) == 32'(DEPTH - 1));
    assign sts.item_is_read    = (item_reg.req_type == tcw_pkg::REQ_READ);
    assign sts.item_is_newline = (item_reg.char_code == tcw_pkg::NEWLINE_CODE);
    assign sts.div_done        = (div_cnt_reg == DCW'(NW));
    assign sts.pos_in_area     = (pos_reg < PW'(area_reg));
    assign sts.copy_done       = (copy_idx_reg >= home);
    assign sts.rowclr_last     = (rowclr_idx_reg == area_reg - NW'(1));
    assign sts.out_free        = !rsp_valid_reg || !rsp_stall;

    // RAM write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(0);
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
        end
        else if (cmd.rowclr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(rowclr_idx_reg);
        end
        else if (pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(pend_addr_reg);
            wr_data = rd_data;
        end
        else if (cmd.exec_print)
        begin
            wr_en   = cursor_in_area;
            wr_addr = AW'(cursor_reg);
            wr_data = {attr_reg, item_reg.char_code};
        end
    end

    // RAM read port select
    assign rd_en   = cmd.exec_read || copy_issue;
    assign rd_addr = cmd.exec_read ? AW'(item_reg.cell_index) : AW'(copy_src);

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state: config, cursor, counters, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= tcw_pkg::SCREEN_WIDTH_RST;
            height_cfg_reg <= tcw_pkg::SCREEN_HEIGHT_RST;
            attr_reg       <= tcw_pkg::TEXT_ATTRIBUTE_RST;
            cursor_reg     <= '0;
            clr_idx_reg    <= '0;
            div_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tcw_pkg::REG_SCREEN_WIDTH:   width_cfg_reg  <= cfg_data[6:0];
                    tcw_pkg::REG_SCREEN_HEIGHT:  height_cfg_reg <= cfg_data[4:0];
                    tcw_pkg::REG_TEXT_ATTRIBUTE: attr_reg       <= cfg_data;
                    default:                     ;
                endcase
            end

            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end

            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end

            if (cmd.set_cursor)
            begin
                cursor_reg <= NW'(pos_reg);
            end
            else if (cmd.scroll_home)
            begin
                cursor_reg <= home;
            end

            pend_reg <= copy_issue;

            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        area_reg <= NW'(area_prod);

        if (cmd.load_item)
        begin
            item_reg <= req_word;
        end

        if (cmd.exec_print)
        begin
            pos_reg <= PW'(cursor_reg) + PW'(1);
        end
        else if (cmd.div_finish)
        begin
            pos_reg <= PW'(cursor_reg) - PW'(rem_reg) + PW'(eff_w);
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= cursor_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end

        if (cmd.scroll_start)
        begin
            copy_idx_reg <= '0;
        end
        else if (copy_issue)
        begin
            copy_idx_reg  <= copy_idx_reg + NW'(1);
        end

        if (copy_issue)
        begin
            pend_addr_reg <= copy_idx_reg;
        end

        if (cmd.rowclr_start)
        begin
            rowclr_idx_reg <= home;
        end
        else if (cmd.rowclr_step)
        begin
            rowclr_idx_reg <= rowclr_idx_reg + NW'(1);
        end

        if (cmd.out_load)
        begin
            rsp_word_reg.cursor_position <= tcw_pkg::POS_W'(cursor_reg);
            if (sts.item_is_read && item_in_range)
            begin
                rsp_word_reg.cell_char      <= rd_data[tcw_pkg::CHAR_W-1:0];
                rsp_word_reg.cell_attribute <= rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            else
            begin
                rsp_word_reg.cell_char      <= '0;
                rsp_word_reg.cell_attribute <= '0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    `TCW_ASSERT_IMP(a_write_in_area, wr_en && !cmd.clr_step, NW'(wr_addr) < area_reg,
        "cell write outside the screen area")
    `TCW_ASSERT_IMP(a_copy_order, pend_reg && copy_issue, pend_addr_reg < copy_src,
        "scroll copy overwrites a row not yet read")

endmodule

// ===== rtl/text_terminal_cell_writer.sv =====
// Top level of the character-cell text terminal writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (with tcw_ram).
//
// Channel  | Handshake              | Word
// req      | req_valid / req_stall  | tcw_pkg::req_word_t (type, char, index)
// rsp      | rsp_valid / rsp_stall  | tcw_pkg::rsp_word_t (cursor, char, attr)
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word in flight at a time. A read goes from decode straight to the result
// register; a plain character first passes through placing, and a newline
// also through the one-bit-per-cycle remainder unit that finds the row start.
// A scroll then does one RAM copy per cycle through the single
// write port, then one cleared cell per cycle on the bottom row.
// After reset a clearing pass writes every cell with req_stall high;
// cfg writes are taken throughout.
// A finished word sits in the rsp register while the next one is accepted.
module text_terminal_cell_writer #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  tcw_pkg::req_word_t              req_word,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tcw_pkg::rsp_word_t              rsp_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tcw_pkg::dp_cmd_t cmd;
    tcw_pkg::dp_sts_t sts;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tcw_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_word  (req_word),
        .rsp_word  (rsp_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
